>>> hdl/tsf_pkg.sv
// tsf_pkg: shared types, character codes and utf-8 constants of the substitution filter
package tsf_pkg;

  // most results one input transaction can cause
  localparam int MAX_RES   = 6;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // ascii characters the filter reacts to
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // utf-8 encodings of the substituted characters
  localparam logic [7:0] U8_LEAD   = 8'hE2;
  localparam logic [7:0] U8_PUNCT  = 8'h80;
  localparam logic [7:0] U8_MATH   = 8'h89;
  localparam logic [7:0] U8_EM     = 8'h94;
  localparam logic [7:0] U8_EN     = 8'h93;
  localparam logic [7:0] U8_ELLIP  = 8'hA6;
  localparam logic [7:0] U8_LE     = 8'hA4;
  localparam logic [7:0] U8_GE     = 8'hA5;
  localparam logic [7:0] U8_LSQ    = 8'h98;
  localparam logic [7:0] U8_RSQ    = 8'h99;
  localparam logic [7:0] U8_LDQ    = 8'h9C;
  localparam logic [7:0] U8_RDQ    = 8'h9D;

  // one result entry
  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       bad;
  } tsf_res_t;

  // word state carried between transactions
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [1:0] cnt;
    logic       esc;
    logic       qs;
  } tsf_state_t;

  // result list produced for one input transaction
  typedef struct packed {
    tsf_res_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]   cnt;
  } tsf_list_t;

  // membership in the escape character set
  function automatic logic is_esc(input logic [7:0] c);
    is_esc = (c == 8'h7B) || (c == 8'h7D) || (c == CH_BSLASH) || (c == 8'h3A) ||
             (c == CH_DASH) || (c == 8'h5F) || (c == 8'h2A) || (c == 8'h60) ||
             (c == CH_EQ) || (c == CH_SQUOTE) || (c == CH_DQUOTE) || (c == CH_DOT) ||
             (c == 8'h2C) || (c == 8'h21) || (c == 8'h5B) || (c == 8'h40) ||
             (c == 8'h23) || (c == CH_LT) || (c == CH_GT);
  endfunction

endpackage

>>> hdl/typographic_substitution_filter.sv
// typographic_substitution_filter: smart quote and dash substitution over a utf-8 byte stream
// Each input transaction (one byte, word_end on the last byte of a word) is held in an
// input register, scanned together with up to two bytes of lookahead in one combinational
// pass, and its results (zero to six) are loaded into a result shift buffer that drains
// one result per cycle while out_ready is high: plain bytes then stream at one transaction
// per cycle, while a three-byte substitution holds the input until its last result is taken.
// A transaction passes the input register and then the result buffer before its first
// result shows. The input register takes the next transaction while the results of the
// previous one are still waiting on out_ready. Results of an item are marked with
// out_run_last on the last one and out_word_done on the final one of a word.
module typographic_substitution_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_word_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_word_done,
  output logic       out_bad_escape
);
  import tsf_pkg::*;

  logic                 in_full_r;
  logic                 in_full_nxt;
  logic [7:0]           in_byte_r;
  logic                 in_end_r;
  tsf_state_t           state_r;
  tsf_state_t           state_nxt;
  tsf_list_t            list;
  tsf_res_t             buf_r   [MAX_RES];
  tsf_res_t             buf_nxt [MAX_RES];
  logic [RES_CNT_W-1:0] buf_cnt_r;
  logic [RES_CNT_W-1:0] buf_cnt_nxt;
  logic                 buf_end_r;
  logic                 in_acc;
  logic                 out_acc;
  logic                 load;

  // handshakes
  assign out_valid = (buf_cnt_r != '0);
  assign out_acc   = out_valid && out_ready;
  assign load      = in_full_r &&
                     ((buf_cnt_r == '0) || ((buf_cnt_r == RES_CNT_W'(1)) && out_ready));
  assign in_ready  = !in_full_r || load;
  assign in_acc    = in_valid && in_ready;

  // substitution scan of the held transaction
  tsf_parse u_parse (
    .st       (state_r),
    .in_byte  (in_byte_r),
    .word_end (in_end_r),
    .list     (list),
    .st_nxt   (state_nxt)
  );

  // input register occupancy
  always_comb begin
    in_full_nxt = in_full_r;
    if (in_acc) begin
      in_full_nxt = 1'b1;
    end else if (load) begin
      in_full_nxt = 1'b0;
    end
  end

  // result buffer: load a fresh list or shift out the head
  always_comb begin
    buf_cnt_nxt = buf_cnt_r;
    for (int i = 0; i < MAX_RES; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        buf_nxt[i] = list.res[i];
      end
      buf_cnt_nxt = list.cnt;
    end else if (out_acc) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_nxt[i] = buf_r[i + 1];
      end
      buf_cnt_nxt = buf_cnt_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
      buf_cnt_r <= '0;
      state_r   <= '0;
    end else begin
      in_full_r <= in_full_nxt;
      buf_cnt_r <= buf_cnt_nxt;
      if (load) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_byte;
      in_end_r  <= in_word_end;
    end
    if (load) begin
      buf_end_r <= in_end_r;
    end
    for (int i = 0; i < MAX_RES; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
  end

  // head of the buffer drives the result channel
  assign out_byte       = buf_r[0].data;
  assign out_byte_valid = buf_r[0].vld;
  assign out_bad_escape = buf_r[0].bad;
  assign out_run_last   = (buf_cnt_r == RES_CNT_W'(1));
  assign out_word_done  = out_run_last && buf_end_r;

endmodule

>>> hdl/tsf_parse.sv
// tsf_parse: combinational scan of lookahead plus new byte into a result list
module tsf_parse (
  input  tsf_pkg::tsf_state_t st,
  input  logic [7:0]          in_byte,
  input  logic                word_end,
  output tsf_pkg::tsf_list_t  list,
  output tsf_pkg::tsf_state_t st_nxt
);
  import tsf_pkg::*;

  // scan the window of up to three bytes, at most three positions
  always_comb begin
    logic [7:0]           w [3];
    logic [1:0]           pc;
    logic [1:0]           n;
    logic [1:0]           pos;
    logic [1:0]           rem;
    logic [1:0]           left;
    logic [7:0]           c;
    logic [7:0]           c1;
    logic [7:0]           c2;
    logic                 stop;
    logic                 esc;
    logic                 qs;
    logic [RES_CNT_W-1:0] k;
    tsf_res_t             res [MAX_RES];

    for (int i = 0; i < MAX_RES; i++) begin
      res[i] = '0;
    end
    k    = '0;
    stop = 1'b0;
    esc  = st.esc;
    qs   = st.qs;
    pos  = 2'd0;
    rem  = 2'd0;
    c    = 8'h00;
    c1   = 8'h00;
    c2   = 8'h00;

    // window: pending bytes then the new byte
    pc   = (st.cnt > 2'd2) ? 2'd2 : st.cnt;
    w[0] = (pc == 2'd0) ? in_byte : st.b0;
    w[1] = (pc == 2'd1) ? in_byte : st.b1;
    w[2] = in_byte;
    n    = pc + 2'd1;

    for (int s = 0; s < 3; s++) begin
      if (!stop && (pos < n)) begin
        rem = n - pos;
        c   = w[pos];
        c1  = (rem >= 2'd2) ? w[pos + 2'd1] : 8'h00;
        c2  = (rem == 2'd3) ? w[2] : 8'h00;

        if (esc) begin
          // escaped byte passes literally
          res[k] = '{data: c, vld: 1'b1, bad: !is_esc(c)};
          k      = k + 1'b1;
          qs     = 1'b1;
          esc    = 1'b0;
          pos    = pos + 2'd1;
        end else if (c == CH_BSLASH) begin
          qs = 1'b1;
          if (rem >= 2'd2) begin
            res[k] = '{data: c1, vld: 1'b1, bad: !is_esc(c1)};
            k      = k + 1'b1;
            pos    = pos + 2'd2;
          end else if (word_end) begin
            // trailing backslash: marker-only result, flagged
            res[k] = '{data: 8'h00, vld: 1'b0, bad: 1'b1};
            k      = k + 1'b1;
            pos    = pos + 2'd1;
          end else begin
            esc = 1'b1;
            pos = pos + 2'd1;
          end
        end else if (c == CH_DASH) begin
          if ((rem == 2'd3) && (c1 == CH_DASH) && (c2 == CH_DASH)) begin
            res[k]        = '{data: U8_LEAD,  vld: 1'b1, bad: 1'b0};
            res[k + 1'b1] = '{data: U8_PUNCT, vld: 1'b1, bad: 1'b0};
            res[k + 2'd2] = '{data: U8_EM,    vld: 1'b1, bad: 1'b0};
            k             = k + 3'd3;
            pos           = pos + 2'd3;
          end else if (!word_end && (rem < 2'd3) &&
                       ((rem == 2'd1) || (c1 == CH_DASH))) begin
            stop = 1'b1;
          end else if ((rem >= 2'd2) && (c1 == CH_DASH)) begin
            res[k]        = '{data: U8_LEAD,  vld: 1'b1, bad: 1'b0};
            res[k + 1'b1] = '{data: U8_PUNCT, vld: 1'b1, bad: 1'b0};
            res[k + 2'd2] = '{data: U8_EN,    vld: 1'b1, bad: 1'b0};
            k             = k + 3'd3;
            pos           = pos + 2'd2;
          end else begin
            res[k] = '{data: c, vld: 1'b1, bad: 1'b0};
            k      = k + 1'b1;
            qs     = 1'b1;
            pos    = pos + 2'd1;
          end
        end else if (c == CH_DOT) begin
          if ((rem == 2'd3) && (c1 == CH_DOT) && (c2 == CH_DOT)) begin
            res[k]        = '{data: U8_LEAD,  vld: 1'b1, bad: 1'b0};
            res[k + 1'b1] = '{data: U8_PUNCT, vld: 1'b1, bad: 1'b0};
            res[k + 2'd2] = '{data: U8_ELLIP, vld: 1'b1, bad: 1'b0};
            k             = k + 3'd3;
            pos           = pos + 2'd3;
          end else if (!word_end && (rem < 2'd3) &&
                       ((rem == 2'd1) || (c1 == CH_DOT))) begin
            stop = 1'b1;
          end else begin
            res[k] = '{data: c, vld: 1'b1, bad: 1'b0};
            k      = k + 1'b1;
            qs     = 1'b1;
            pos    = pos + 2'd1;
          end
        end else if ((c == CH_LT) || (c == CH_GT)) begin
          if ((rem >= 2'd2) && (c1 == CH_EQ)) begin
            res[k]        = '{data: U8_LEAD, vld: 1'b1, bad: 1'b0};
            res[k + 1'b1] = '{data: U8_MATH, vld: 1'b1, bad: 1'b0};
            res[k + 2'd2] = '{data: (c == CH_LT) ? U8_LE : U8_GE, vld: 1'b1, bad: 1'b0};
            k             = k + 3'd3;
            pos           = pos + 2'd2;
          end else if ((rem == 2'd1) && !word_end) begin
            stop = 1'b1;
          end else begin
            res[k] = '{data: c, vld: 1'b1, bad: 1'b0};
            k      = k + 1'b1;
            qs     = 1'b1;
            pos    = pos + 2'd1;
          end
        end else if ((c == CH_SQUOTE) || (c == CH_DQUOTE)) begin
          // curly quote, left until a literal byte has gone out
          res[k]        = '{data: U8_LEAD,  vld: 1'b1, bad: 1'b0};
          res[k + 1'b1] = '{data: U8_PUNCT, vld: 1'b1, bad: 1'b0};
          if (c == CH_SQUOTE) begin
            res[k + 2'd2] = '{data: qs ? U8_RSQ : U8_LSQ, vld: 1'b1, bad: 1'b0};
          end else begin
            res[k + 2'd2] = '{data: qs ? U8_RDQ : U8_LDQ, vld: 1'b1, bad: 1'b0};
          end
          k   = k + 3'd3;
          pos = pos + 2'd1;
        end else begin
          res[k] = '{data: c, vld: 1'b1, bad: 1'b0};
          k      = k + 1'b1;
          qs     = 1'b1;
          pos    = pos + 2'd1;
        end
      end
    end

    // undecided tail becomes the new lookahead
    left          = n - pos;
    st_nxt.cnt    = left;
    st_nxt.b0     = (left >= 2'd1) ? w[pos] : 8'h00;
    st_nxt.b1     = (left == 2'd2) ? w[pos + 2'd1] : 8'h00;
    st_nxt.esc    = esc;
    st_nxt.qs     = qs;

    // word end: at least one result, then clear everything
    if (word_end) begin
      if (k == '0) begin
        res[0] = '0;
        k      = RES_CNT_W'(1);
      end
      st_nxt = '0;
    end

    for (int i = 0; i < MAX_RES; i++) begin
      list.res[i] = res[i];
    end
    list.cnt = k;
  end

endmodule

>>> hdl/tsf_checker.sv
// tsf_checker: port-level assertions on the substitution filter, bound to the top level
module tsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_run_last,
  input logic       out_word_done,
  input logic       out_bad_escape
);

  // end of word is always the last result of its transaction
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_done |-> out_run_last)
    else $error("word_done without run_last");

  // a marker-only result carries no byte and closes its transaction
  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> (out_byte == 8'h00) && out_run_last)
    else $error("marker-only result malformed");

  // a flagged marker only comes from a backslash that ends the word
  a_trailing_escape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid && out_bad_escape |-> out_word_done)
    else $error("flagged marker outside word end");

  // a stalled transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_byte_valid) && $stable(out_run_last) && $stable(out_word_done) &&
      $stable(out_bad_escape))
    else $error("result changed while stalled");

endmodule

bind typographic_substitution_filter tsf_checker u_tsf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_run_last   (out_run_last),
  .out_word_done  (out_word_done),
  .out_bad_escape (out_bad_escape)
);
